[rtl/cau_pkg.sv]
// ----------------------------------------------------------------------------
// cau_pkg
// Shared widths, operation codes and pipeline stage type for the complex ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

    localparam int W    = 16;
    localparam int FRAC = 8;
    localparam int PW   = 2 * W;
    localparam int SW   = PW + 1;
    localparam int NW   = SW + FRAC;
    localparam int QB   = W + 1;
    localparam int DEXT = PW + QB;

    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_SUB = 3'd1;
    localparam logic [2:0] MODE_NEG = 3'd2;
    localparam logic [2:0] MODE_MUL = 3'd3;
    localparam logic [2:0] MODE_DIV = 3'd4;
    localparam logic [2:0] MODE_EQ  = 3'd5;

    typedef struct packed {
        logic [2:0]           mode;
        logic signed [W-1:0]  a_re;
        logic signed [W-1:0]  a_im;
        logic signed [W-1:0]  b_re;
        logic signed [W-1:0]  b_im;
        logic signed [W-1:0]  smp_re;
        logic signed [W-1:0]  smp_im;
        logic                 smp_sat;
        logic                 eq;
        logic signed [PW-1:0] p_rr;
        logic signed [PW-1:0] p_ii;
        logic signed [PW-1:0] p_ri;
        logic signed [PW-1:0] p_ir;
        logic signed [PW-1:0] sq_r;
        logic signed [PW-1:0] sq_i;
        logic signed [SW-1:0] mul_re;
        logic signed [SW-1:0] mul_im;
        logic signed [SW-1:0] dn_re;
        logic signed [SW-1:0] dn_im;
        logic [PW-1:0]        den;
        logic signed [W-1:0]  mres_re;
        logic signed [W-1:0]  mres_im;
        logic                 msat;
        logic                 dz;
        logic                 neg_re;
        logic                 neg_im;
        logic [NW-1:0]        rem_re;
        logic [NW-1:0]        rem_im;
        logic                 ovf_re;
        logic                 ovf_im;
        logic [QB-1:0]        q_re;
        logic [QB-1:0]        q_im;
    } work_t;

    // saturate a W+1 bit sum to W bits
    function automatic logic signed [W-1:0] sat_sum(input logic signed [W:0] x);
        logic signed [W-1:0] r;
        if (x[W] != x[W-1])
            r = x[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        else
            r = x[W-1:0];
        return r;
    endfunction

    function automatic logic sum_ovf(input logic signed [W:0] x);
        return x[W] != x[W-1];
    endfunction

endpackage

`default_nettype wire

[rtl/cau_stream_if.sv]
// ----------------------------------------------------------------------------
// cau_cmd_if / cau_rsp_if
// Valid/ready channels for complex ALU operand and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface cau_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    mode;
    logic signed [cau_pkg::W-1:0]  a_re;
    logic signed [cau_pkg::W-1:0]  a_im;
    logic signed [cau_pkg::W-1:0]  b_re;
    logic signed [cau_pkg::W-1:0]  b_im;

    modport source (output valid, mode, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, mode, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if;
    logic                          valid;
    logic                          ready;
    logic signed [cau_pkg::W-1:0]  res_re;
    logic signed [cau_pkg::W-1:0]  res_im;
    logic                          equal;
    logic                          div_by_zero;
    logic                          saturated;

    modport source (output valid, res_re, res_im, equal, div_by_zero, saturated,
                    input ready);
    modport sink   (input valid, res_re, res_im, equal, div_by_zero, saturated,
                    output ready);
endinterface

`default_nettype wire

[rtl/complex_arith_unit.sv]
// ----------------------------------------------------------------------------
// complex_arith_unit
// Pipelined complex ALU on signed Q8.8 operands: add, sub, negate, multiply,
// divide and compare, with saturation and divide-by-zero flags.
// ----------------------------------------------------------------------------
// One beat enters per cycle while the pipeline is not holding; the restoring
// divider resolves one quotient bit per stage over 17 stages after the
// multiply, sum and range-check stages.
// The whole pipeline advances together and holds while a result waits.
`default_nettype none

module complex_arith_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cau_cmd_if.sink    cmd,
    cau_rsp_if.source  rsp
);

    localparam int S_DIV0 = 5;
    localparam int NST    = S_DIV0 + cau_pkg::QB;
    localparam int W      = cau_pkg::W;
    localparam int SW     = cau_pkg::SW;

    localparam logic signed [SW-1:0] MUL_MAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] MUL_MIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic [cau_pkg::QB-1:0] Q_MAX = {2'b00, {(W-1){1'b1}}};
    localparam logic [cau_pkg::QB-1:0] Q_MIN = {2'b01, {(W-1){1'b0}}};

    cau_pkg::work_t  stg_reg  [NST];
    cau_pkg::work_t  stg_next [NST];
    logic [NST-1:0]  vld_reg;

    logic            adv;
    logic            out_vld_reg;
    logic signed [W-1:0] res_re_reg, res_im_reg, res_re_next, res_im_next;
    logic            eq_reg, dz_reg, sat_reg, eq_next, dz_next, sat_next;

    assign adv       = !out_vld_reg || rsp.ready;
    assign cmd.ready = adv;

    // stage 0: capture, simple ops
    always_comb
    begin
        logic signed [W:0] s_re, s_im;
        stg_next[0]      = '0;
        stg_next[0].mode = cmd.mode;
        stg_next[0].a_re = cmd.a_re;
        stg_next[0].a_im = cmd.a_im;
        stg_next[0].b_re = cmd.b_re;
        stg_next[0].b_im = cmd.b_im;
        case (cmd.mode)
            cau_pkg::MODE_ADD:
            begin
                s_re = (W+1)'(cmd.a_re) + (W+1)'(cmd.b_re);
                s_im = (W+1)'(cmd.a_im) + (W+1)'(cmd.b_im);
            end
            cau_pkg::MODE_SUB:
            begin
                s_re = (W+1)'(cmd.a_re) - (W+1)'(cmd.b_re);
                s_im = (W+1)'(cmd.a_im) - (W+1)'(cmd.b_im);
            end
            default:
            begin
                s_re = (W+1)'(0) - (W+1)'(cmd.b_re);
                s_im = (W+1)'(0) - (W+1)'(cmd.b_im);
            end
        endcase
        stg_next[0].smp_re  = cau_pkg::sat_sum(s_re);
        stg_next[0].smp_im  = cau_pkg::sat_sum(s_im);
        stg_next[0].smp_sat = cau_pkg::sum_ovf(s_re) | cau_pkg::sum_ovf(s_im);
        stg_next[0].eq      = (cmd.a_re == cmd.b_re) && (cmd.a_im == cmd.b_im);
    end

    // stage 1: products
    always_comb
    begin
        stg_next[1]      = stg_reg[0];
        stg_next[1].p_rr = stg_reg[0].a_re * stg_reg[0].b_re;
        stg_next[1].p_ii = stg_reg[0].a_im * stg_reg[0].b_im;
        stg_next[1].p_ri = stg_reg[0].a_re * stg_reg[0].b_im;
        stg_next[1].p_ir = stg_reg[0].a_im * stg_reg[0].b_re;
        stg_next[1].sq_r = stg_reg[0].b_re * stg_reg[0].b_re;
        stg_next[1].sq_i = stg_reg[0].b_im * stg_reg[0].b_im;
    end

    // stage 2: sums
    always_comb
    begin
        stg_next[2]        = stg_reg[1];
        stg_next[2].mul_re = SW'(stg_reg[1].p_rr) - SW'(stg_reg[1].p_ii);
        stg_next[2].mul_im = SW'(stg_reg[1].p_ri) + SW'(stg_reg[1].p_ir);
        stg_next[2].dn_re  = SW'(stg_reg[1].p_rr) + SW'(stg_reg[1].p_ii);
        stg_next[2].dn_im  = SW'(stg_reg[1].p_ir) - SW'(stg_reg[1].p_ri);
        stg_next[2].den    = unsigned'(stg_reg[1].sq_r) + unsigned'(stg_reg[1].sq_i);
    end

    // stage 3: product rescale and clamp, dividend magnitudes
    always_comb
    begin
        logic signed [SW-1:0] sh_re, sh_im;
        logic [SW-1:0]        m_re, m_im;
        logic                 o_re, o_im;
        stg_next[3] = stg_reg[2];
        sh_re = stg_reg[2].mul_re >>> cau_pkg::FRAC;
        sh_im = stg_reg[2].mul_im >>> cau_pkg::FRAC;
        o_re  = (sh_re > MUL_MAX) || (sh_re < MUL_MIN);
        o_im  = (sh_im > MUL_MAX) || (sh_im < MUL_MIN);
        stg_next[3].mres_re = o_re ? (sh_re[SW-1] ? MUL_MIN[W-1:0] : MUL_MAX[W-1:0])
                                   : sh_re[W-1:0];
        stg_next[3].mres_im = o_im ? (sh_im[SW-1] ? MUL_MIN[W-1:0] : MUL_MAX[W-1:0])
                                   : sh_im[W-1:0];
        stg_next[3].msat    = o_re | o_im;
        m_re = stg_reg[2].dn_re[SW-1] ? unsigned'(-stg_reg[2].dn_re)
                                      : unsigned'(stg_reg[2].dn_re);
        m_im = stg_reg[2].dn_im[SW-1] ? unsigned'(-stg_reg[2].dn_im)
                                      : unsigned'(stg_reg[2].dn_im);
        stg_next[3].neg_re = stg_reg[2].dn_re[SW-1];
        stg_next[3].neg_im = stg_reg[2].dn_im[SW-1];
        stg_next[3].rem_re = {m_re, {cau_pkg::FRAC{1'b0}}};
        stg_next[3].rem_im = {m_im, {cau_pkg::FRAC{1'b0}}};
        stg_next[3].dz     = (stg_reg[2].den == '0);
        stg_next[3].q_re   = '0;
        stg_next[3].q_im   = '0;
    end

    // stage 4: quotient range check
    always_comb
    begin
        logic [cau_pkg::DEXT-1:0] lim;
        stg_next[4] = stg_reg[3];
        lim = {stg_reg[3].den, {cau_pkg::QB{1'b0}}};
        stg_next[4].ovf_re = cau_pkg::DEXT'(stg_reg[3].rem_re) >= lim;
        stg_next[4].ovf_im = cau_pkg::DEXT'(stg_reg[3].rem_im) >= lim;
    end

    // restoring divider, one quotient bit per stage
    for (genvar j = 0; j < cau_pkg::QB; j++)
    begin : g_div
        localparam int K = cau_pkg::QB - 1 - j;
        always_comb
        begin
            logic [cau_pkg::DEXT-1:0] dsh, r_re, r_im;
            stg_next[S_DIV0+j] = stg_reg[S_DIV0+j-1];
            dsh  = cau_pkg::DEXT'(stg_reg[S_DIV0+j-1].den) << K;
            r_re = cau_pkg::DEXT'(stg_reg[S_DIV0+j-1].rem_re);
            r_im = cau_pkg::DEXT'(stg_reg[S_DIV0+j-1].rem_im);
            if (r_re >= dsh)
            begin
                stg_next[S_DIV0+j].rem_re  = cau_pkg::NW'(r_re - dsh);
                stg_next[S_DIV0+j].q_re[K] = 1'b1;
            end
            if (r_im >= dsh)
            begin
                stg_next[S_DIV0+j].rem_im  = cau_pkg::NW'(r_im - dsh);
                stg_next[S_DIV0+j].q_im[K] = 1'b1;
            end
        end
    end

    // result select
    always_comb
    begin
        cau_pkg::work_t    s;
        logic              sr, si;
        logic [cau_pkg::QB-1:0] nq_re, nq_im;
        s  = stg_reg[NST-1];
        sr = s.ovf_re || (s.neg_re ? (s.q_re > Q_MIN) : (s.q_re > Q_MAX));
        si = s.ovf_im || (s.neg_im ? (s.q_im > Q_MIN) : (s.q_im > Q_MAX));
        nq_re = -s.q_re;
        nq_im = -s.q_im;
        res_re_next = '0;
        res_im_next = '0;
        eq_next     = 1'b0;
        dz_next     = 1'b0;
        sat_next    = 1'b0;
        case (s.mode)
            cau_pkg::MODE_ADD, cau_pkg::MODE_SUB, cau_pkg::MODE_NEG:
            begin
                res_re_next = s.smp_re;
                res_im_next = s.smp_im;
                sat_next    = s.smp_sat;
            end
            cau_pkg::MODE_MUL:
            begin
                res_re_next = s.mres_re;
                res_im_next = s.mres_im;
                sat_next    = s.msat;
            end
            cau_pkg::MODE_DIV:
            begin
                if (s.dz)
                    dz_next = 1'b1;
                else
                begin
                    if (sr)
                        res_re_next = s.neg_re ? Q_MIN[W-1:0] : Q_MAX[W-1:0];
                    else
                        res_re_next = s.neg_re ? nq_re[W-1:0] : s.q_re[W-1:0];
                    if (si)
                        res_im_next = s.neg_im ? Q_MIN[W-1:0] : Q_MAX[W-1:0];
                    else
                        res_im_next = s.neg_im ? nq_im[W-1:0] : s.q_im[W-1:0];
                    sat_next = sr | si;
                end
            end
            cau_pkg::MODE_EQ:
                eq_next = s.eq;
            default:
                eq_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[NST-2:0], cmd.valid};
            out_vld_reg <= vld_reg[NST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NST; i++)
                stg_reg[i] <= stg_next[i];
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            eq_reg     <= eq_next;
            dz_reg     <= dz_next;
            sat_reg    <= sat_next;
        end
    end

    assign rsp.valid       = out_vld_reg;
    assign rsp.res_re      = res_re_reg;
    assign rsp.res_im      = res_im_reg;
    assign rsp.equal       = eq_reg;
    assign rsp.div_by_zero = dz_reg;
    assign rsp.saturated   = sat_reg;

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.div_by_zero |-> !rsp.saturated && rsp.res_re == '0
                                         && rsp.res_im == '0)
        else $error("divide-by-zero beat with nonzero result");

    a_eq_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.equal |-> !rsp.saturated && !rsp.div_by_zero
                                   && rsp.res_re == '0 && rsp.res_im == '0)
        else $error("compare beat with nonzero result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.res_re)
                                    && $stable(rsp.res_im))
        else $error("stalled result beat changed");

endmodule

`default_nettype wire

[tb/cau_checker.sv]
// ----------------------------------------------------------------------------
// cau_checker
// Watches the operand and result channels of complex_arith_unit, predicts
// each result from the accepted operand beat and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cau_checker (
    input  logic     clk,
    input  logic     rst_n,
    cau_cmd_if       cmd,
    cau_rsp_if       rsp,
    output int       errors,
    output int       pending,
    output int       results_seen
);

    typedef struct packed {
        logic [15:0] re;
        logic [15:0] im;
        logic        eq;
        logic        dz;
        logic        sat;
    } alu_res_t;

    localparam longint MAXV = 32767;
    localparam longint MINV = -32768;
    localparam longint QLIM = longint'(1) << 40;

    alu_res_t expected_q[$];

    function automatic longint clip(input longint v, inout logic sat);
        if (v > MAXV)
        begin
            sat = 1'b1;
            return MAXV;
        end
        if (v < MINV)
        begin
            sat = 1'b1;
            return MINV;
        end
        return v;
    endfunction

    function automatic longint floor_shift(input longint v);
        return v >>> cau_pkg::FRAC;
    endfunction

    function automatic longint div_trunc(input longint num, input longint den);
        longint m;
        longint q;
        longint r;
        m = (num < 0) ? -num : num;
        q = m / den;
        r = m % den;
        if (q > QLIM)
            q = QLIM;
        for (int i = 0; i < cau_pkg::FRAC; i++)
        begin
            q = (q >= QLIM) ? QLIM : (q << 1);
            r = r << 1;
            if (r >= den)
            begin
                r = r - den;
                if (q < QLIM)
                    q = q + 1;
            end
        end
        return (num < 0) ? -q : q;
    endfunction

    function automatic alu_res_t predict_alu(input logic [2:0] mode,
        input longint ar, input longint ai, input longint br, input longint bi);
        alu_res_t o;
        longint rr;
        longint ri;
        longint den;
        logic sat;
        rr = 0;
        ri = 0;
        sat = 1'b0;
        o = '0;
        case (mode)
            cau_pkg::MODE_ADD:
            begin
                rr = clip(ar + br, sat);
                ri = clip(ai + bi, sat);
            end
            cau_pkg::MODE_SUB:
            begin
                rr = clip(ar - br, sat);
                ri = clip(ai - bi, sat);
            end
            cau_pkg::MODE_NEG:
            begin
                rr = clip(-br, sat);
                ri = clip(-bi, sat);
            end
            cau_pkg::MODE_MUL:
            begin
                rr = clip(floor_shift(ar * br - ai * bi), sat);
                ri = clip(floor_shift(ar * bi + ai * br), sat);
            end
            cau_pkg::MODE_DIV:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                    o.dz = 1'b1;
                else
                begin
                    rr = clip(div_trunc(ar * br + ai * bi, den), sat);
                    ri = clip(div_trunc(ai * br - ar * bi, den), sat);
                end
            end
            cau_pkg::MODE_EQ:
                o.eq = (ar == br) && (ai == bi);
            default: ;
        endcase
        o.re = rr[15:0];
        o.im = ri[15:0];
        o.sat = sat;
        return o;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        alu_res_t e;
        if (!rst_n)
        begin
            errors <= 0;
            results_seen <= 0;
            expected_q.delete();
        end
        else
        begin
            if (cmd.valid && cmd.ready)
                expected_q.push_back(predict_alu(cmd.mode, longint'(cmd.a_re),
                    longint'(cmd.a_im), longint'(cmd.b_re), longint'(cmd.b_im)));
            if (rsp.valid && rsp.ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat re=%h im=%h", $time,
                             rsp.res_re, rsp.res_im);
                    errors <= errors + 1;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (e.re !== rsp.res_re || e.im !== rsp.res_im
                        || e.eq !== rsp.equal || e.dz !== rsp.div_by_zero
                        || e.sat !== rsp.saturated)
                    begin
                        $display("%0t: mismatch exp re=%h im=%h eq=%b dz=%b sat=%b",
                                 $time, e.re, e.im, e.eq, e.dz, e.sat);
                        $display("%0t:          got re=%h im=%h eq=%b dz=%b sat=%b",
                                 $time, rsp.res_re, rsp.res_im, rsp.equal,
                                 rsp.div_by_zero, rsp.saturated);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

[tb/tb_complex_arith_unit.sv]
// ----------------------------------------------------------------------------
// tb_complex_arith_unit
// Directed corner beats and random operand streams for every mode of the
// complex ALU, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_complex_arith_unit;

    localparam int N_RANDOM = 680;
    localparam int LATENCY  = 23;
    localparam int WD_LIMIT = 20000;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   results_seen;
    int   idle_cycles;
    int   beats_sent;
    logic stim_done;

    cau_cmd_if cmd ();
    cau_rsp_if rsp ();

    complex_arith_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    cau_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rsp          (rsp),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #6 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] pick_val();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            4: return 16'(signed'($urandom_range(0, 1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_beat(input logic [2:0] m, input logic [15:0] ar,
                             input logic [15:0] ai, input logic [15:0] br,
                             input logic [15:0] bi);
        cmd.valid <= 1'b1;
        cmd.mode  <= m;
        cmd.a_re  <= ar;
        cmd.a_im  <= ai;
        cmd.b_re  <= br;
        cmd.b_im  <= bi;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_gapped(input logic [2:0] m, input logic [15:0] ar,
                               input logic [15:0] ai, input logic [15:0] br,
                               input logic [15:0] bi);
        int g;
        send_beat(m, ar, ai, br, bi);
        g = gap_len();
        if (g > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    initial
    begin
        logic [2:0] m;
        logic [15:0] v;
        cmd.valid <= 1'b0;
        cmd.mode  <= cau_pkg::MODE_ADD;
        cmd.a_re  <= '0;
        cmd.a_im  <= '0;
        cmd.b_re  <= '0;
        cmd.b_im  <= '0;
        beats_sent = 0;
        stim_done = 1'b0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gapped(cau_pkg::MODE_ADD, 16'h7fff, 16'h8000, 16'h0001, 16'hffff);
        send_gapped(cau_pkg::MODE_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_gapped(cau_pkg::MODE_SUB, 16'h8000, 16'h7fff, 16'h0001, 16'hffff);
        send_gapped(cau_pkg::MODE_SUB, 16'h1234, 16'h0100, 16'h0034, 16'h0200);
        send_gapped(cau_pkg::MODE_NEG, 16'h0000, 16'h0000, 16'h8000, 16'h8000);
        send_gapped(cau_pkg::MODE_NEG, 16'hffff, 16'h0001, 16'h7fff, 16'h0001);
        send_gapped(cau_pkg::MODE_MUL, 16'h0100, 16'h0100, 16'h0100, 16'hff00);
        send_gapped(cau_pkg::MODE_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_gapped(cau_pkg::MODE_MUL, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
        send_gapped(cau_pkg::MODE_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000);
        send_gapped(cau_pkg::MODE_DIV, 16'h0100, 16'h0200, 16'h0000, 16'h0000);
        send_gapped(cau_pkg::MODE_DIV, 16'h0300, 16'h0100, 16'h0100, 16'h0000);
        send_gapped(cau_pkg::MODE_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);
        send_gapped(cau_pkg::MODE_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_gapped(cau_pkg::MODE_DIV, 16'hff01, 16'h0005, 16'h0003, 16'hfffd);
        send_gapped(cau_pkg::MODE_EQ,  16'h1234, 16'h8000, 16'h1234, 16'h8000);
        send_gapped(cau_pkg::MODE_EQ,  16'h1234, 16'h8000, 16'h1234, 16'h8001);
        send_gapped(3'd6,     16'h7fff, 16'h7fff, 16'h0001, 16'h0001);
        send_gapped(3'd7,     16'h8000, 16'h8000, 16'h0000, 16'h0000);

        // drain fully once before the random part
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            m = 3'($urandom_range(0, 7));
            if (m > 3'd5 && $urandom_range(0, 3) != 0)
                m = 3'($urandom_range(0, 5));
            v = pick_val();
            if (m == cau_pkg::MODE_EQ && $urandom_range(0, 1))
                send_gapped(m, v, 16'($urandom), v, 16'($urandom));
            else if (m == cau_pkg::MODE_EQ && $urandom_range(0, 1))
            begin
                v = 16'($urandom);
                send_gapped(m, v, v ^ 16'h00f0, v, v ^ 16'h00f0);
            end
            else if (m == cau_pkg::MODE_DIV && $urandom_range(0, 9) == 0)
                send_gapped(m, pick_val(), pick_val(), 16'h0000, 16'h0000);
            else if ($urandom_range(0, 7) == 0)
                send_beat(m, v, v, v, v);
            else
                send_gapped(m, v, pick_val(), pick_val(), pick_val());
            if (i == N_RANDOM / 2)
            begin
                cmd.valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
        end
        cmd.valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial
    begin
        int g;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                g = gap_len();
                rsp.ready <= 1'b0;
                repeat (g + 1) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WD_LIMIT)
            begin
                $display("watchdog: no beat accepted for %0d cycles", WD_LIMIT);
                $display("[complex_arith_unit] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        @(posedge rst_n);
        wait (stim_done);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        $display("Covered %0d operand beats across add, sub, negate, multiply,", beats_sent);
        $display("divide, compare and unused modes; %0d results checked.", results_seen);
        if (errors == 0 && pending == 0)
            $display("[complex_arith_unit] OK");
        else
            $display("[complex_arith_unit] ERROR");
        $finish;
    end
endmodule

[complex_arith_unit.f]
rtl/cau_pkg.sv
rtl/cau_stream_if.sv
rtl/complex_arith_unit.sv
tb/cau_checker.sv
tb/tb_complex_arith_unit.sv
